// ===== sv/mpba_pkg.sv =====
// ----------------------------------------------------------------------------
// mpba_pkg
// Shared constants, codes and result type of the multi-pool bitmap allocator.
// ----------------------------------------------------------------------------
package mpba_pkg;

   localparam int NUM_POOLS_DEF  = 16;
   localparam int MAX_BLOCKS_DEF = 1024;
   localparam int WORD_BITS_DEF  = 32;

   // fixed field widths on the ports
   localparam int ACT_W      = 2;
   localparam int ID_W       = 5;
   localparam int BLK_W      = 10;
   localparam int SIZE_W     = 16;
   localparam int REQ_CNT_W  = 11;
   localparam int CNT_OUT_W  = 11;
   localparam int STAT_W     = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [ACT_W-1:0] {
      ACT_CREATE = 2'd0,
      ACT_ALLOC  = 2'd1,
      ACT_FREE   = 2'd2,
      ACT_STATS  = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_SLOT   = 3'd1,
      ST_BAD_POOL  = 3'd2,
      ST_POOL_FULL = 3'd3,
      ST_NOT_ALLOC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_POOL,
      S_SCAN,
      S_FADDR,
      S_FCHK,
      S_DONE
   } fsm_type;

   typedef struct packed {
      status_type             status;
      logic [ID_W-1:0]        pool_id;
      logic [BLK_W-1:0]       granted;
      logic [SIZE_W-1:0]      size;
      logic [CNT_OUT_W-1:0]   total;
      logic [CNT_OUT_W-1:0]   used;
      logic [CNT_OUT_W-1:0]   free_cnt;
   } result_type;

endpackage

// ===== sv/mpba_ram.sv =====
// ----------------------------------------------------------------------------
// mpba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multi_pool_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// multi_pool_bitmap_allocator
// Fixed-block pool allocator, first fit over a per-pool bitmap held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | tuser         | tdata
//  req_    | in  | action        | pool_id, block_index, new_block_size,
//          |     |               | new_block_count
//  rsp_    | out | status        | result_pool_id, granted_block, size,
//          |     |               | total, used, free
//
// Stats reads the pool entry. Free reads the pool entry, then the bitmap word,
// then clears the bit. Create zeroes the pool's bitmap words one per cycle
// through the bitmap write port. Alloc scans the pool's words one word per
// cycle through the bitmap read port, up to the first free block or last word.
// No clearing pass after reset: a pool's words are zeroed when it is created.
// A waiting result sits in the output register; the next request is taken
// meanwhile, and a new result waits in the done state until that one is gone.
// ----------------------------------------------------------------------------
module multi_pool_bitmap_allocator
   import mpba_pkg::*;
#(
   parameter int NUM_POOLS  = NUM_POOLS_DEF,
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ACT_W-1:0]      req_tuser,   // action
   // pool_id[4:0], block_index[14:5], new_block_size[30:15],
   // new_block_count[41:31], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STAT_W-1:0]     rsp_tuser,   // status
   // result_pool_id[4:0], granted_block[14:5], pool_block_size[30:15],
   // pool_total[41:31], pool_used[52:42], pool_avail[63:53]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int WPP      = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WPP_W    = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int BM_DEPTH = NUM_POOLS * WPP;
   localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
   localparam int SLOT_W   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int PC_W     = $clog2(NUM_POOLS + 1);
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int BIT_W    = $clog2(WORD_BITS);
   localparam int PW       = SIZE_W + 2 * CNT_W;
   // exact division of a block index by WORD_BITS via reciprocal
   localparam int SH       = BLK_W + BIT_W;
   localparam int RECIP    = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW       = BLK_W + 2;
   localparam int PROD_W   = BLK_W + RW;

   fsm_type                state_ff, state_in;
   logic [PC_W-1:0]        pc_ff, pc_in;
   action_type             act_ff, act_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [BM_AW-1:0]       base_ff, base_in;
   logic [BM_AW-1:0]       waddr_ff, waddr_in;
   logic [WPP_W-1:0]       wc_ff, wc_in;
   logic [WPP_W-1:0]       q_ff, q_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       bb_ff, bb_in;
   logic [BIT_W-1:0]       bitpos_ff, bitpos_in;
   logic [SIZE_W-1:0]      pe_size_ff, pe_size_in;
   logic [CNT_W-1:0]       pe_count_ff, pe_count_in;
   logic [CNT_W-1:0]       pe_free_ff, pe_free_in;
   result_type             res_ff, res_in;
   result_type             rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   pool_we;
   logic [SLOT_W-1:0]      pool_waddr, pool_raddr;
   logic [PW-1:0]          pool_wdata, pool_rdata;
   logic                   bm_we;
   logic [BM_AW-1:0]       bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;

   action_type             req_action;
   logic [ID_W-1:0]        req_id;
   logic [BLK_W-1:0]       req_blk;
   logic [SIZE_W-1:0]      req_size;
   logic [REQ_CNT_W-1:0]   req_count;
   logic [CNT_W-1:0]       sat_count;
   logic [SLOT_W-1:0]      req_slot;
   logic                   accept;
   logic                   slots_full;
   logic                   id_ok;
   logic [SIZE_W-1:0]      pr_size;
   logic [CNT_W-1:0]       pr_count;
   logic [CNT_W-1:0]       pr_free;
   logic                   blk_bad;
   logic [PROD_W-1:0]      prod;
   logic [WORD_BITS-1:0]   avail;
   logic                   hit;
   logic [BIT_W-1:0]       hit_idx;
   logic                   last_word;
   logic                   bit_set;
   logic                   out_free;

   function automatic result_type mk_res(
      input status_type       st,
      input logic [ID_W-1:0]  id,
      input logic [BLK_W-1:0] grant,
      input logic [SIZE_W-1:0] sz,
      input logic [CNT_W-1:0] tot,
      input logic [CNT_W-1:0] fr
   );
      result_type r;
      r.status   = st;
      r.pool_id  = id;
      r.granted  = grant;
      r.size     = sz;
      r.total    = CNT_OUT_W'(tot);
      r.used     = CNT_OUT_W'(tot - fr);
      r.free_cnt = CNT_OUT_W'(fr);
      return r;
   endfunction

   // ---------------------------------------------------------------- memories
   mpba_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_POOLS)
   ) u_pool_ram (
      .clock   (clock),
      .wr_en   (pool_we),
      .wr_addr (pool_waddr),
      .wr_data (pool_wdata),
      .rd_addr (pool_raddr),
      .rd_data (pool_rdata)
   );

   mpba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BM_DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   // ---------------------------------------------------------------- decode
   assign req_action = action_type'(req_tuser);
   assign req_id     = req_tdata[4:0];
   assign req_blk    = req_tdata[14:5];
   assign req_size   = req_tdata[30:15];
   assign req_count  = req_tdata[41:31];
   assign accept     = req_tvalid && req_tready;
   assign sat_count  = (32'(req_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                     : CNT_W'(req_count);
   assign req_slot   = SLOT_W'(req_id - ID_W'(1));
   assign slots_full = 32'(pc_ff) >= NUM_POOLS;
   assign id_ok      = (req_id != '0) && (32'(req_id) <= 32'(pc_ff));

   assign pr_size  = pool_rdata[PW-1 -: SIZE_W];
   assign pr_count = pool_rdata[2*CNT_W-1 -: CNT_W];
   assign pr_free  = pool_rdata[CNT_W-1:0];
   assign blk_bad  = (32'(blk_ff) >= 32'(pr_count)) || (32'(blk_ff) >= MAX_BLOCKS);
   assign prod     = PROD_W'(blk_ff) * PROD_W'(RECIP);

   // first clear bit of the current word, limited to blocks below the count
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         avail[i] = !bm_rdata[i] && (32'(rem_ff) > i);
      end
      hit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            hit_idx = BIT_W'(i);
         end
      end
   end

   assign hit       = |avail;
   assign last_word = 32'(rem_ff) <= WORD_BITS;
   assign bit_set   = bm_rdata[bitpos_ff];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_CREATE) begin
                  state_in = slots_full ? S_DONE : S_CLEAR;
               end else begin
                  state_in = id_ok ? S_POOL : S_DONE;
               end
            end
         end
         S_CLEAR: begin
            if (wc_ff == WPP_W'(WPP - 1)) begin
               state_in = S_DONE;
            end
         end
         S_POOL: begin
            unique case (act_ff)
               ACT_ALLOC:  state_in = (pr_free == '0) ? S_DONE : S_SCAN;
               ACT_FREE:   state_in = blk_bad ? S_DONE : S_FADDR;
               ACT_STATS:  state_in = S_DONE;
               ACT_CREATE: state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (hit || last_word) begin
               state_in = S_DONE;
            end
         end
         S_FADDR: state_in = S_FCHK;
         S_FCHK:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      req_tready  = 1'b0;
      pc_in       = pc_ff;
      act_in      = act_ff;
      id_in       = id_ff;
      slot_in     = slot_ff;
      blk_in      = blk_ff;
      base_in     = base_ff;
      waddr_in    = waddr_ff;
      wc_in       = wc_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      bb_in       = bb_ff;
      bitpos_in   = bitpos_ff;
      pe_size_in  = pe_size_ff;
      pe_count_in = pe_count_ff;
      pe_free_in  = pe_free_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;
      pool_we     = 1'b0;
      pool_waddr  = slot_ff;
      pool_wdata  = '0;
      pool_raddr  = req_slot;
      bm_we       = 1'b0;
      bm_waddr    = waddr_ff;
      bm_wdata    = '0;
      bm_raddr    = waddr_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               act_in  = req_action;
               id_in   = req_id;
               slot_in = req_slot;
               blk_in  = req_blk;
               base_in = BM_AW'(32'(req_slot) * WPP);
               if (req_action == ACT_CREATE) begin
                  if (slots_full) begin
                     res_in = mk_res(ST_NO_SLOT, '0, '0, '0, '0, '0);
                  end else begin
                     pool_we    = 1'b1;
                     pool_waddr = SLOT_W'(pc_ff);
                     pool_wdata = {req_size, sat_count, sat_count};
                     pc_in      = PC_W'(pc_ff + 1'b1);
                     base_in    = BM_AW'(32'(pc_ff) * WPP);
                     wc_in      = '0;
                     res_in     = mk_res(ST_OK, ID_W'(32'(pc_ff) + 1), '0,
                                         req_size, sat_count, sat_count);
                  end
               end else if (!id_ok) begin
                  res_in = mk_res(ST_BAD_POOL, '0, '0, '0, '0, '0);
               end
            end
         end
         S_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = BM_AW'(base_ff + BM_AW'(wc_ff));
            wc_in    = WPP_W'(wc_ff + 1'b1);
         end
         S_POOL: begin
            pe_size_in  = pr_size;
            pe_count_in = pr_count;
            pe_free_in  = pr_free;
            bm_raddr    = base_ff;
            waddr_in    = base_ff;
            rem_in      = pr_count;
            bb_in       = '0;
            q_in        = WPP_W'(prod >> SH);
            res_in      = mk_res(ST_OK, id_ff, '0, pr_size, pr_count, pr_free);
            unique case (act_ff)
               ACT_ALLOC: begin
                  if (pr_free == '0) begin
                     res_in.status = ST_POOL_FULL;
                  end
               end
               ACT_FREE: begin
                  if (blk_bad) begin
                     res_in.status = ST_NOT_ALLOC;
                  end
               end
               ACT_STATS:  ;
               ACT_CREATE: ;
            endcase
         end
         S_SCAN: begin
            // prefetch the next word while checking this one
            bm_raddr = BM_AW'(waddr_ff + 1'b1);
            if (hit) begin
               bm_we      = 1'b1;
               bm_waddr   = waddr_ff;
               bm_wdata   = bm_rdata | (WORD_BITS'(1) << hit_idx);
               pool_we    = 1'b1;
               pool_wdata = {pe_size_ff, pe_count_ff, CNT_W'(pe_free_ff - 1'b1)};
               res_in     = mk_res(ST_OK, id_ff, BLK_W'(bb_ff + CNT_W'(hit_idx)),
                                   pe_size_ff, pe_count_ff,
                                   CNT_W'(pe_free_ff - 1'b1));
            end else if (last_word) begin
               res_in = mk_res(ST_POOL_FULL, id_ff, '0, pe_size_ff, pe_count_ff,
                               pe_free_ff);
            end else begin
               waddr_in = BM_AW'(waddr_ff + 1'b1);
               bb_in    = CNT_W'(32'(bb_ff) + WORD_BITS);
               rem_in   = CNT_W'(32'(rem_ff) - WORD_BITS);
            end
         end
         S_FADDR: begin
            bitpos_in = BIT_W'(blk_ff - BLK_W'(32'(q_ff) * WORD_BITS));
            bm_raddr  = BM_AW'(base_ff + BM_AW'(q_ff));
            waddr_in  = BM_AW'(base_ff + BM_AW'(q_ff));
         end
         S_FCHK: begin
            if (!bit_set) begin
               res_in = mk_res(ST_NOT_ALLOC, id_ff, '0, pe_size_ff, pe_count_ff,
                               pe_free_ff);
            end else begin
               bm_we      = 1'b1;
               bm_waddr   = waddr_ff;
               bm_wdata   = bm_rdata & ~(WORD_BITS'(1) << bitpos_ff);
               pool_we    = 1'b1;
               pool_wdata = {pe_size_ff, pe_count_ff, CNT_W'(pe_free_ff + 1'b1)};
               res_in     = mk_res(ST_OK, id_ff, '0, pe_size_ff, pe_count_ff,
                                   CNT_W'(pe_free_ff + 1'b1));
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (state_ff == S_DONE && out_free) ? 1'b1
                       : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      id_ff       <= id_in;
      slot_ff     <= slot_in;
      blk_ff      <= blk_in;
      base_ff     <= base_in;
      waddr_ff    <= waddr_in;
      wc_ff       <= wc_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      bb_ff       <= bb_in;
      bitpos_ff   <= bitpos_in;
      pe_size_ff  <= pe_size_in;
      pe_count_ff <= pe_count_in;
      pe_free_ff  <= pe_free_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.free_cnt, rsp_ff.used, rsp_ff.total, rsp_ff.size,
                        rsp_ff.granted, rsp_ff.pool_id};

endmodule

// ===== bench/multi_pool_bitmap_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pool_bitmap_allocator_test
// Self-checking bench for the pool allocator. A ledger class keeps its own
// copy of the pool tables and bitmaps, works out the response due for each
// accepted request and checks responses in order. Directed requests cover the
// bad-pool, pool-full and not-allocated codes and edge counts; random traffic
// then runs under several back-pressure and idle mixes.
// ----------------------------------------------------------------------------
module multi_pool_bitmap_allocator_test
   import mpba_pkg::*;
();

   // -------------------------------------------------------------------------
   class pool_ledger;
      result_type            due_q[$];
      int unsigned           pools_made;
      logic [SIZE_W-1:0]     size_of  [NUM_POOLS_DEF];
      logic [CNT_OUT_W-1:0]  total_of [NUM_POOLS_DEF];
      logic [CNT_OUT_W-1:0]  avail_of [NUM_POOLS_DEF];
      bit [MAX_BLOCKS_DEF-1:0] held   [NUM_POOLS_DEF];
      int unsigned           errors;
      int unsigned           checked;
      int unsigned           status_seen [8];

      function new();
         pools_made = 0;
         errors     = 0;
         checked    = 0;
         foreach (size_of[i]) begin
            size_of[i]  = '0;
            total_of[i] = '0;
            avail_of[i] = '0;
            held[i]     = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // response carrying the pool's current counts; slot < 0 gives zeros
      function result_type pool_view(status_type st, int slot, logic [ID_W-1:0] id,
                                     logic [BLK_W-1:0] granted);
         result_type r;
         r = '0;
         r.status  = st;
         r.pool_id = id;
         r.granted = granted;
         if (slot >= 0) begin
            r.size     = size_of[slot];
            r.total    = total_of[slot];
            r.used     = total_of[slot] - avail_of[slot];
            r.free_cnt = avail_of[slot];
         end
         return r;
      endfunction

      // random block currently held in a pool, or any index if none is held
      function logic [BLK_W-1:0] pick_held_block(int slot);
         int unsigned start;
         int unsigned b;
         if (total_of[slot] == 0 || avail_of[slot] == total_of[slot])
            return BLK_W'($urandom_range(0, MAX_BLOCKS_DEF - 1));
         start = $urandom_range(0, total_of[slot] - 1);
         for (int unsigned k = 0; k < total_of[slot]; k++) begin
            b = (start + k) % total_of[slot];
            if (held[slot][b]) return BLK_W'(b);
         end
         return BLK_W'(start);
      endfunction

      function void record_request(action_type act, logic [ID_W-1:0] id,
                                   logic [BLK_W-1:0] blk, logic [SIZE_W-1:0] sz,
                                   logic [REQ_CNT_W-1:0] cnt);
         int slot;
         int unsigned s;
         result_type r;
         if (act == ACT_CREATE) begin
            if (pools_made >= NUM_POOLS_DEF) begin
               due_q.push_back(pool_view(ST_NO_SLOT, -1, '0, '0));
               return;
            end
            s = pools_made;
            pools_made++;
            size_of[s]  = sz;
            total_of[s] = CNT_OUT_W'((cnt > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : cnt);
            avail_of[s] = total_of[s];
            held[s]     = '0;
            due_q.push_back(pool_view(ST_OK, s, ID_W'(s + 1), '0));
            return;
         end
         if (id == 0 || id > pools_made) begin
            due_q.push_back(pool_view(ST_BAD_POOL, -1, '0, '0));
            return;
         end
         slot = id - 1;
         case (act)
            ACT_ALLOC: begin
               r = pool_view(ST_POOL_FULL, slot, id, '0);
               if (avail_of[slot] != 0) begin
                  // first fit: lowest clear bit below the block count
                  for (int unsigned b = 0; b < total_of[slot]; b++) begin
                     if (!held[slot][b]) begin
                        held[slot][b] = 1'b1;
                        avail_of[slot]--;
                        r = pool_view(ST_OK, slot, id, BLK_W'(b));
                        break;
                     end
                  end
               end
               due_q.push_back(r);
            end
            ACT_FREE: begin
               if (blk >= total_of[slot] || !held[slot][blk]) begin
                  due_q.push_back(pool_view(ST_NOT_ALLOC, slot, id, '0));
               end else begin
                  held[slot][blk] = 1'b0;
                  avail_of[slot]++;
                  due_q.push_back(pool_view(ST_OK, slot, id, '0));
               end
            end
            default: due_q.push_back(pool_view(ST_OK, slot, id, '0));
         endcase
      endfunction

      function void compare_field(string what, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      function void check_result(logic [STAT_W-1:0] st, logic [RSP_DATA_W-1:0] data);
         result_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, status %0d data %h", $time, st, data);
            return;
         end
         want = due_q.pop_front();
         checked++;
         status_seen[st]++;
         compare_field("status",    want.status,   st);
         compare_field("pool id",   want.pool_id,  data[4:0]);
         compare_field("granted",   want.granted,  data[14:5]);
         compare_field("blk size",  want.size,     data[30:15]);
         compare_field("total",     want.total,    data[41:31]);
         compare_field("used",      want.used,     data[52:42]);
         compare_field("free",      want.free_cnt, data[63:53]);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ACT_W-1:0]      req_tuser;   // action
   // pool_id, block_index, new_block_size, new_block_count, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [STAT_W-1:0]     rsp_tuser;   // status
   // result_pool_id, granted_block, pool_block_size, pool_total, pool_used,
   // pool_avail
   logic [RSP_DATA_W-1:0] rsp_tdata;

   pool_ledger  ledger;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_cycles;

   multi_pool_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: ready drawn each falling edge, long hold counted down here
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= stall_pct);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_result(rsp_tuser, rsp_tdata);
   end

   // called just after a falling edge, returns just after one
   task automatic send_item(action_type act, logic [ID_W-1:0] id, logic [BLK_W-1:0] blk,
                            logic [SIZE_W-1:0] sz, logic [REQ_CNT_W-1:0] cnt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = act;
      req_tdata  = {6'b0, cnt, sz, blk, id};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      ledger.record_request(act, id, blk, sz, cnt);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (ledger.due_q.size() != 0) @(negedge clock);
   endtask

   task automatic send_random();
      int unsigned r;
      int unsigned alloc_share;
      action_type act;
      logic [ID_W-1:0] id;
      logic [BLK_W-1:0] blk;
      logic [SIZE_W-1:0] sz;
      logic [REQ_CNT_W-1:0] cnt;
      r   = $urandom_range(0, 99);
      id  = ID_W'($urandom_range(0, 31));
      blk = BLK_W'($urandom_range(0, 1023));
      sz  = SIZE_W'($urandom);
      cnt = REQ_CNT_W'($urandom_range(0, 2047));
      if (r < 4 || ledger.pools_made == 0) begin
         act = ACT_CREATE;
         r = $urandom_range(0, 9);
         if (r < 7) cnt = REQ_CNT_W'($urandom_range(1, 64));
         else if (r < 9) cnt = REQ_CNT_W'($urandom_range(0, 1024));
      end else if (r < 9) begin
         // noise: any pool id, any block
         act = action_type'($urandom_range(1, 3));
      end else begin
         // the big pool gets mostly allocations so the scan goes deep
         if ($urandom_range(0, 9) < 4) id = ID_W'(2);
         else id = ID_W'($urandom_range(1, ledger.pools_made));
         alloc_share = (id == 2) ? 80 : 50;
         r = $urandom_range(0, 99);
         if (r < alloc_share) begin
            act = ACT_ALLOC;
         end else if (r < alloc_share + ((id == 2) ? 12 : 35)) begin
            act = ACT_FREE;
            if ($urandom_range(0, 3) != 0) blk = ledger.pick_held_block(id - 1);
         end else begin
            act = ACT_STATS;
         end
      end
      send_item(act, id, blk, sz, cnt);
   endtask

   task automatic run_directed();
      send_item(ACT_STATS,  5'd0,  10'd0,    16'd0,      11'd0);    // id zero
      send_item(ACT_ALLOC,  5'd1,  10'd0,    16'd0,      11'd0);    // nothing created
      send_item(ACT_FREE,   5'd31, 10'd1023, 16'hffff,   11'h7ff);
      send_item(ACT_CREATE, 5'd0,  10'd0,    16'hffff,   11'd0);    // pool 1, empty
      send_item(ACT_ALLOC,  5'd1,  10'd0,    16'd0,      11'd0);    // full at once
      send_item(ACT_FREE,   5'd1,  10'd0,    16'd0,      11'd0);    // out of range
      send_item(ACT_CREATE, 5'd31, 10'd1023, 16'd0,      11'h7ff);  // pool 2, saturated
      send_item(ACT_CREATE, 5'd0,  10'd0,    16'h1234,   11'd1);    // pool 3
      send_item(ACT_ALLOC,  5'd3,  10'd0,    16'd0,      11'd0);
      send_item(ACT_ALLOC,  5'd3,  10'd0,    16'd0,      11'd0);    // now full
      send_item(ACT_FREE,   5'd3,  10'd0,    16'd0,      11'd0);
      send_item(ACT_FREE,   5'd3,  10'd0,    16'd0,      11'd0);    // already free
      send_item(ACT_FREE,   5'd3,  10'd1023, 16'd0,      11'd0);    // out of range
      send_item(ACT_ALLOC,  5'd2,  10'd0,    16'd0,      11'd0);
      send_item(ACT_ALLOC,  5'd2,  10'd0,    16'd0,      11'd0);
      send_item(ACT_FREE,   5'd2,  10'd0,    16'd0,      11'd0);
      send_item(ACT_ALLOC,  5'd2,  10'd0,    16'd0,      11'd0);    // hole reused
      send_item(ACT_FREE,   5'd2,  10'd1023, 16'd0,      11'd0);    // clear bit
      send_item(ACT_STATS,  5'd2,  10'd0,    16'd0,      11'd0);
      send_item(ACT_STATS,  5'd17, 10'd0,    16'd0,      11'd0);
      send_item(ACT_CREATE, 5'd0,  10'd0,    16'h8001,   11'd1024); // pool 4
      send_item(ACT_STATS,  5'd4,  10'd0,    16'd0,      11'd0);
      send_item(ACT_STATS,  5'd5,  10'd0,    16'd0,      11'd0);    // not yet created
      send_item(ACT_CREATE, 5'd0,  10'd0,    16'h00ff,   11'd33);   // pool 5, two words
   endtask

   initial begin
      ledger        = new();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_cycles   = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; hold_cycles = 300; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         repeat (225) send_random();
         wait_drained();
      end

      repeat (40) @(negedge clock);
      $display("Checked %0d responses over %0d pools: ok %0d, no slot %0d, bad pool %0d,",
               ledger.checked, ledger.pools_made, ledger.status_seen[ST_OK],
               ledger.status_seen[ST_NO_SLOT], ledger.status_seen[ST_BAD_POOL]);
      $display("  pool full %0d, not allocated %0d; four idle/stall mixes plus a long hold.",
               ledger.status_seen[ST_POOL_FULL], ledger.status_seen[ST_NOT_ALLOC]);
      if (ledger.errors == 0 && ledger.due_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
